// ===== hdl/hsn_pkg.sv =====
// Shared widths, register indexes and transfer types of the height-field slope block.
`default_nettype none

package hsn_pkg;

  localparam int HEIGHT_W    = 16;
  localparam int DIFF_W      = HEIGHT_W + 2;
  localparam int SCALE_W     = 16;
  localparam int SLOPE_W     = 24;
  localparam int POS_W       = 10;
  localparam int SIZE_W      = 11;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 16;
  localparam int PROD_W      = DIFF_W + SCALE_W + 1;
  localparam int MIN_SIZE    = 2;
  localparam int SIZE_RESET  = 1024;
  localparam int QUEUE_DEPTH = 4;
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_AW-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_X_SCALE     = 2'd2;
  localparam logic [CFG_AW-1:0] REG_Y_SCALE     = 2'd3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = 24'sh7FFFFF;
  localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = 24'sh800000;

  typedef struct packed {
    logic [SCALE_W-1:0] x;
    logic [SCALE_W-1:0] y;
  } hsn_scale_t;

  // Everything the back end needs for the normals that one sample completes.
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx0;
    logic signed [DIFF_W-1:0] dy0;
    logic signed [DIFF_W-1:0] dx1;
    logic signed [DIFF_W-1:0] dy1;
    logic signed [DIFF_W-1:0] dx2;
    logic signed [DIFF_W-1:0] dy2;
    logic [POS_W-1:0]         col;
    logic [POS_W-1:0]         row;
    logic                     has1;
    logic                     has2;
  } hsn_job_t;

endpackage

`default_nettype wire

// ===== hdl/hsn_if.sv =====
// Channel interfaces of the height-field slope block: samples in, normals out, configuration.
`default_nettype none

interface hsn_in_if import hsn_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] height_sample;

  modport source (output valid, output height_sample, input ready);
  modport sink (input valid, input height_sample, output ready);
endinterface

interface hsn_out_if import hsn_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SLOPE_W-1:0] slope_x;
  logic signed [SLOPE_W-1:0] slope_y;
  logic [POS_W-1:0]          column;
  logic [POS_W-1:0]          row;
  logic                      frame_end;

  modport source (output valid, output slope_x, output slope_y, output column, output row,
                  output frame_end, input ready);
  modport sink (input valid, input slope_x, input slope_y, input column, input row,
                input frame_end, output ready);
endinterface

interface hsn_cfg_if import hsn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/hsn_front.sv =====
// Front end: raster counters, row store, window and the differences for each sample.
`default_nettype none

module hsn_front import hsn_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  hsn_in_if.sink                        in_ch,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wlast,
  input  logic [$clog2(MAX_HEIGHT)-1:0] hlast,
  input  logic                          restart,
  input  logic [QLVL_W-1:0]             q_level,
  output logic                          push,
  output hsn_job_t                      push_job
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int EW = 2 * HEIGHT_W;

  function automatic logic signed [DIFF_W-1:0] sub_h(input logic signed [HEIGHT_W-1:0] a,
                                                     input logic signed [HEIGHT_W-1:0] b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  function automatic logic signed [DIFF_W-1:0] dbl(input logic signed [DIFF_W-1:0] v);
    return v <<< 1;
  endfunction

  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          accept;
  logic [AW-1:0] rd_addr;

  // Each entry holds the newest row above in the upper half and the one above that below.
  logic [EW-1:0] mem [MAX_WIDTH];
  logic [EW-1:0] rd_q_r;
  logic [EW-1:0] byp_data_r;
  logic          byp_r;
  logic [EW-1:0] cur_e_r;
  logic [EW-1:0] nxt_e;

  logic                       s2_valid_r;
  logic signed [HEIGHT_W-1:0] s2_s_r;
  logic [AW-1:0]              s2_col_r;
  logic [POS_W-1:0]           s2_cpos_r;
  logic [POS_W-1:0]           s2_q_r;
  logic                       s2_first_r;
  logic                       s2_second_r;
  logic                       s2_last_col_r;
  logic                       s2_top_r;
  logic                       s2_q0_r;
  logic                       s2_last_row_r;

  logic signed [HEIGHT_W-1:0] win0_r;
  logic signed [HEIGHT_W-1:0] win1_r;
  logic signed [HEIGHT_W-1:0] win2_r;

  logic signed [HEIGHT_W-1:0] up;
  logic signed [HEIGHT_W-1:0] up2;
  logic signed [HEIGHT_W-1:0] nx;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (q_level + QLVL_W'(s2_valid_r)) < QLVL_W'(QUEUE_DEPTH);
  assign rd_addr     = (col_r == wlast) ? '0 : col_r + 1'b1;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_r == wlast) begin
        col_nxt = '0;
        row_nxt = (row_r == hlast) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s2_valid_r <= accept;
    end
  end

  // The entry of the next column is fetched as the sample arrives, so that it is at hand
  // when the sample reaches the second stage.
  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      mem[s2_col_r] <= {s2_s_r, up};
    end
    if (accept) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // A fetch of the entry that is being written in the same cycle takes the new value.
  always_ff @(posedge clk) begin
    if (accept) begin
      byp_r         <= s2_valid_r && (s2_col_r == rd_addr);
      byp_data_r    <= {s2_s_r, up};
      s2_s_r        <= in_ch.height_sample;
      s2_col_r      <= col_r;
      s2_cpos_r     <= POS_W'(col_r);
      s2_q_r        <= POS_W'(row_r) - 1'b1;
      s2_first_r    <= col_r == '0;
      s2_second_r   <= col_r == AW'(1);
      s2_last_col_r <= col_r == wlast;
      s2_top_r      <= row_r == '0;
      s2_q0_r       <= row_r == RW'(1);
      s2_last_row_r <= row_r == hlast;
    end
  end

  assign nxt_e = byp_r ? byp_data_r : rd_q_r;
  assign up    = cur_e_r[EW-1:HEIGHT_W];
  assign up2   = cur_e_r[HEIGHT_W-1:0];
  assign nx    = nxt_e[EW-1:HEIGHT_W];

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      cur_e_r <= nxt_e;
      win0_r  <= up;
      win1_r  <= s2_s_r;
      win2_r  <= win1_r;
    end
  end

  // Edges extrapolate linearly by one cell, which doubles the one-sided difference.
  always_comb begin
    if (s2_first_r) begin
      push_job.dx0 = dbl(sub_h(nx, up));
    end else if (s2_last_col_r) begin
      push_job.dx0 = dbl(sub_h(up, win0_r));
    end else begin
      push_job.dx0 = sub_h(nx, win0_r);
    end
    push_job.dy0 = s2_q0_r ? dbl(sub_h(s2_s_r, up)) : sub_h(s2_s_r, up2);
    push_job.dx1 = s2_second_r ? dbl(sub_h(s2_s_r, win1_r)) : sub_h(s2_s_r, win2_r);
    push_job.dy1 = dbl(sub_h(win1_r, win0_r));
    push_job.dx2 = dbl(sub_h(s2_s_r, win1_r));
    push_job.dy2 = dbl(sub_h(s2_s_r, up));
    push_job.col  = s2_cpos_r;
    push_job.row  = s2_q_r;
    push_job.has1 = s2_last_row_r && !s2_first_r;
    push_job.has2 = s2_last_row_r && s2_last_col_r;
  end

  assign push = s2_valid_r && !s2_top_r;

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (col_r <= wlast) && (row_r <= hlast))
    else $error("sample accepted outside the configured grid");

  a_edge_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> !(s2_first_r && s2_last_col_r))
    else $error("first and last column coincide");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_level < QLVL_W'(QUEUE_DEPTH))
    else $error("job pushed into a full queue");

endmodule

`default_nettype wire

// ===== hdl/hsn_queue.sv =====
// Short job queue that decouples the front end from the back end.
`default_nettype none

module hsn_queue import hsn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hsn_job_t          push_job,
  input  logic              pop,
  output hsn_job_t          head,
  output logic [QLVL_W-1:0] level
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  hsn_job_t          slots_r [QUEUE_DEPTH];
  logic [PW-1:0]     wr_r;
  logic [PW-1:0]     rd_r;
  logic [QLVL_W-1:0] level_r, level_nxt;

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      level_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= push_job;
    end
  end

  assign head  = slots_r[rd_r];
  assign level = level_r;

  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= QLVL_W'(QUEUE_DEPTH))
    else $error("queue level beyond its depth");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> level_r != '0)
    else $error("pop from an empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r != QLVL_W'(QUEUE_DEPTH)) |-> (wr_r - rd_r) == PW'(level_r))
    else $error("queue pointers disagree with the level");

endmodule

`default_nettype wire

// ===== hdl/hsn_back.sv =====
// Back end: walks the normals of each job, scales, negates and saturates the slopes.
`default_nettype none

module hsn_back import hsn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  hsn_scale_t scale,
  input  hsn_job_t   head,
  input  logic       avail,
  output logic       pop,
  hsn_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    SUB0 = 3'b001,
    SUB1 = 3'b010,
    SUB2 = 3'b100
  } hsn_sub_t;

  function automatic logic signed [SLOPE_W-1:0] sat_neg(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] n;
    n = -p;
    if (n > PROD_W'(SLOPE_MAX)) begin
      return SLOPE_MAX;
    end else if (n < PROD_W'(SLOPE_MIN)) begin
      return SLOPE_MIN;
    end
    return SLOPE_W'(n);
  endfunction

  hsn_sub_t sub_r, sub_nxt, sub_next_in_job;

  logic                     out_en;
  logic                     mul_en;
  logic                     take;
  logic                     done;
  logic signed [DIFF_W-1:0] sel_dx;
  logic signed [DIFF_W-1:0] sel_dy;
  logic [POS_W-1:0]         sel_col;
  logic [POS_W-1:0]         sel_row;
  logic                     sel_last;
  logic signed [SCALE_W:0]  sx;
  logic signed [SCALE_W:0]  sy;

  logic                     mul_valid_r;
  logic signed [PROD_W-1:0] mul_x_r;
  logic signed [PROD_W-1:0] mul_y_r;
  logic [POS_W-1:0]         mul_col_r;
  logic [POS_W-1:0]         mul_row_r;
  logic                     mul_last_r;

  logic                      out_valid_r;
  logic signed [SLOPE_W-1:0] out_x_r;
  logic signed [SLOPE_W-1:0] out_y_r;
  logic [POS_W-1:0]          out_col_r;
  logic [POS_W-1:0]          out_row_r;
  logic                      out_last_r;

  // The second normal of a job lies one column to the left in the row below,
  // the third is the bottom right corner of the grid.
  always_comb begin
    case (sub_r)
      SUB1: begin
        sel_dx          = head.dx1;
        sel_dy          = head.dy1;
        sel_col         = head.col - 1'b1;
        sel_row         = head.row + 1'b1;
        sel_last        = 1'b0;
        done            = !head.has2;
        sub_next_in_job = SUB2;
      end
      SUB2: begin
        sel_dx          = head.dx2;
        sel_dy          = head.dy2;
        sel_col         = head.col;
        sel_row         = head.row + 1'b1;
        sel_last        = 1'b1;
        done            = 1'b1;
        sub_next_in_job = SUB0;
      end
      default: begin
        sel_dx          = head.dx0;
        sel_dy          = head.dy0;
        sel_col         = head.col;
        sel_row         = head.row;
        sel_last        = 1'b0;
        done            = !head.has1 && !head.has2;
        sub_next_in_job = head.has1 ? SUB1 : SUB2;
      end
    endcase
  end

  assign out_en  = !out_valid_r || out_ch.ready;
  assign mul_en  = !mul_valid_r || out_en;
  assign take    = avail && mul_en;
  assign pop     = take && done;
  assign sub_nxt = take ? (done ? SUB0 : sub_next_in_job) : sub_r;
  assign sx      = $signed({1'b0, scale.x});
  assign sy      = $signed({1'b0, scale.y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= SUB0;
      mul_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      if (mul_en) begin
        mul_valid_r <= take;
      end
      if (out_en) begin
        out_valid_r <= mul_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mul_x_r    <= sel_dx * sx;
      mul_y_r    <= sel_dy * sy;
      mul_col_r  <= sel_col;
      mul_row_r  <= sel_row;
      mul_last_r <= sel_last;
    end
    if (out_en && mul_valid_r) begin
      out_x_r    <= sat_neg(mul_x_r);
      out_y_r    <= sat_neg(mul_y_r);
      out_col_r  <= mul_col_r;
      out_row_r  <= mul_row_r;
      out_last_r <= mul_last_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.slope_x   = out_x_r;
  assign out_ch.slope_y   = out_y_r;
  assign out_ch.column    = out_col_r;
  assign out_ch.row       = out_row_r;
  assign out_ch.frame_end = out_last_r;

  a_take_avail: assert property (@(posedge clk) disable iff (!rst_n)
    (sub_r != SUB0) |-> avail)
    else $error("job left the queue before all its normals were sent");

  a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
    mul_valid_r && !out_en |=> mul_valid_r && $stable(mul_x_r) && $stable(mul_col_r))
    else $error("product stage lost an item while stalled");

  a_corner_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && (sub_r == SUB2) |-> pop)
    else $error("corner normal is not the end of its job");

endmodule

`default_nettype wire

// ===== hdl/heightfield_slope_normals_top.sv =====
// Top level of the height-field slope block: configuration registers and the three stages.
//
// Height samples enter on in_ch in raster order, one transfer per grid point. Each transfer
// with row >= 1 completes the normal of the point directly above it; in the last row a
// transfer also completes the point to its left, and the last sample the corner, flagged
// with frame_end. Normals leave on out_ch as (slope_x, slope_y, column, row).
// A sample is taken every cycle while in_ch.ready is high. The job of a transfer that
// completes a normal passes the front-end registers, the job queue, the product register
// and the output register before out_ch.valid rises; output trails input by about one grid
// row. In the last row up to three normals come per sample and the single output port sets
// the rate there to one normal per cycle while out_ch is ready. The two rows above the
// current one sit in a row store with one read and one write each cycle, read one column
// ahead; a four-entry job queue lets the front end run on while the output is stalled, and
// in_ch.ready drops once that queue, counting the sample still in the front end, is full.
// cfg_ch is always ready; register 0 and 1 set grid width and height (clamped to 2 and the
// maximum size) and restart the grid at its first point, registers 2 and 3 set the x and y
// Q8.8 scales. Write them only while no item is in flight.
// Reset (rst_n low at a clock edge) empties the pipeline, restarts the grid and loads a
// 1024 x 1024 grid with unit scale; the row store needs no clearing.
`default_nettype none

module heightfield_slope_normals_top import hsn_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  hsn_in_if.sink    in_ch,
  hsn_out_if.source out_ch,
  hsn_cfg_if.sink   cfg_ch
);

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int RW      = $clog2(MAX_HEIGHT);
  localparam int MW      = (AW > RW) ? AW : RW;
  localparam int CW      = (MW + 1 > SIZE_W) ? MW + 1 : SIZE_W;
  localparam int W_RESET = (MAX_WIDTH < SIZE_RESET) ? MAX_WIDTH : SIZE_RESET;
  localparam int H_RESET = (MAX_HEIGHT < SIZE_RESET) ? MAX_HEIGHT : SIZE_RESET;

  logic [AW-1:0]     wlast_r, wlast_nxt;
  logic [RW-1:0]     hlast_r, hlast_nxt;
  hsn_scale_t        scale_r, scale_nxt;
  logic              restart;
  logic              cfg_fire;
  logic [CW-1:0]     size_v;
  logic              push;
  hsn_job_t          push_job;
  logic              pop;
  hsn_job_t          head;
  logic [QLVL_W-1:0] q_level;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign size_v       = CW'(cfg_ch.data[SIZE_W-1:0]);

  always_comb begin
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    scale_nxt = scale_r;
    restart   = 1'b0;
    if (cfg_fire) begin
      case (cfg_ch.addr)
        REG_GRID_WIDTH: begin
          restart = 1'b1;
          if (size_v < CW'(MIN_SIZE)) begin
            wlast_nxt = AW'(MIN_SIZE - 1);
          end else if (size_v > CW'(MAX_WIDTH)) begin
            wlast_nxt = AW'(MAX_WIDTH - 1);
          end else begin
            wlast_nxt = AW'(size_v - 1'b1);
          end
        end
        REG_GRID_HEIGHT: begin
          restart = 1'b1;
          if (size_v < CW'(MIN_SIZE)) begin
            hlast_nxt = RW'(MIN_SIZE - 1);
          end else if (size_v > CW'(MAX_HEIGHT)) begin
            hlast_nxt = RW'(MAX_HEIGHT - 1);
          end else begin
            hlast_nxt = RW'(size_v - 1'b1);
          end
        end
        REG_X_SCALE: begin
          scale_nxt.x = cfg_ch.data[SCALE_W-1:0];
        end
        REG_Y_SCALE: begin
          scale_nxt.y = cfg_ch.data[SCALE_W-1:0];
        end
        default: begin
          scale_nxt = scale_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r   <= AW'(W_RESET - 1);
      hlast_r   <= RW'(H_RESET - 1);
      scale_r.x <= SCALE_RESET;
      scale_r.y <= SCALE_RESET;
    end else begin
      wlast_r <= wlast_nxt;
      hlast_r <= hlast_nxt;
      scale_r <= scale_nxt;
    end
  end

  hsn_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .wlast    (wlast_r),
    .hlast    (hlast_r),
    .restart  (restart),
    .q_level  (q_level),
    .push     (push),
    .push_job (push_job)
  );

  hsn_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .level    (q_level)
  );

  hsn_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .scale  (scale_r),
    .head   (head),
    .avail  (q_level != '0),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the height-field slope block: raster grids in, normals checked.
module tb_top;
  import hsn_pkg::*;

  localparam int GRID_MAX     = 1024;
  localparam int RANDOM_ITEMS = 190;
  localparam int GAP_MAX      = 19;
  localparam int SETTLE       = 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int REPORT_CAP   = 40;

  typedef enum int {FILL_NOISE, FILL_GENTLE, FILL_STEEP, FILL_EXTREME} fill_style_e;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope_x;
    logic signed [SLOPE_W-1:0] slope_y;
    logic [POS_W-1:0]          column;
    logic [POS_W-1:0]          row;
    logic                      frame_end;
  } normal_t;

  // Tracks the grid position, the two rows above and the window of the current row, and
  // holds the normals that accepted samples have made due.
  class slope_board;
    logic [SIZE_W-1:0]          width_reg;
    logic [SIZE_W-1:0]          height_reg;
    logic [SCALE_W-1:0]         x_scale;
    logic [SCALE_W-1:0]         y_scale;
    logic signed [HEIGHT_W-1:0] older_row [GRID_MAX];
    logic signed [HEIGHT_W-1:0] newer_row [GRID_MAX];
    logic signed [HEIGHT_W-1:0] up_prev;
    logic signed [HEIGHT_W-1:0] cur_prev;
    logic signed [HEIGHT_W-1:0] cur_prev2;
    int unsigned                col_pos;
    int unsigned                row_pos;
    normal_t                    due [$];
    int                         errors;
    int                         samples;
    int                         normals;

    function new();
      width_reg  = SIZE_RESET;
      height_reg = SIZE_RESET;
      x_scale    = SCALE_RESET;
      y_scale    = SCALE_RESET;
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      up_prev   = '0;
      cur_prev  = '0;
      cur_prev2 = '0;
      col_pos   = 0;
      row_pos   = 0;
      errors    = 0;
      samples   = 0;
      normals   = 0;
    endfunction

    function int unsigned clamp_size(logic [SIZE_W-1:0] v);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > GRID_MAX) return GRID_MAX;
      return v;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_GRID_WIDTH: begin
          width_reg = val[SIZE_W-1:0];
          col_pos   = 0;
          row_pos   = 0;
        end
        REG_GRID_HEIGHT: begin
          height_reg = val[SIZE_W-1:0];
          col_pos    = 0;
          row_pos    = 0;
        end
        REG_X_SCALE: x_scale = val;
        REG_Y_SCALE: y_scale = val;
        default: ;
      endcase
    endfunction

    function logic signed [SLOPE_W-1:0] scaled_slope(longint diff, logic [SCALE_W-1:0] k);
      longint p;
      p = -diff * longint'(k);
      if (p > longint'(SLOPE_MAX)) p = longint'(SLOPE_MAX);
      if (p < longint'(SLOPE_MIN)) p = longint'(SLOPE_MIN);
      return p[SLOPE_W-1:0];
    endfunction

    function void push_normal(longint dx, longint dy, int unsigned c, int unsigned r, bit last);
      normal_t n;
      n.slope_x   = scaled_slope(dx, x_scale);
      n.slope_y   = scaled_slope(dy, y_scale);
      n.column    = c[POS_W-1:0];
      n.row       = r[POS_W-1:0];
      n.frame_end = last;
      due.push_back(n);
    endfunction

    // One sample completes the point above it; in the last row also the point to its left
    // and, at the last column, the corner.
    function void note_sample(logic signed [HEIGHT_W-1:0] s);
      int unsigned                w;
      int unsigned                h;
      int unsigned                c;
      int unsigned                r;
      logic signed [HEIGHT_W-1:0] above;
      longint                     su;
      longint                     up;
      longint                     up2;
      longint                     upw;
      longint                     cur1;
      longint                     cur2;
      longint                     dx;
      longint                     dy;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      if (col_pos >= w || row_pos >= h) begin
        col_pos = 0;
        row_pos = 0;
      end
      c     = col_pos;
      r     = row_pos;
      above = newer_row[c];
      su    = s;
      up    = above;
      up2   = older_row[c];
      upw   = up_prev;
      cur1  = cur_prev;
      cur2  = cur_prev2;
      samples++;
      if (r >= 1) begin
        // The border is extrapolated by one cell, so edge differences are doubled.
        if (c == 0) dx = 2 * (longint'(newer_row[1]) - up);
        else if (c == w - 1) dx = 2 * (up - upw);
        else dx = longint'(newer_row[c + 1]) - upw;
        dy = (r == 1) ? 2 * (su - up) : su - up2;
        push_normal(dx, dy, c, r - 1, 1'b0);
        if (r == h - 1) begin
          if (c >= 1) begin
            dx = (c == 1) ? 2 * (su - cur1) : su - cur2;
            dy = 2 * (cur1 - upw);
            push_normal(dx, dy, c - 1, r, 1'b0);
          end
          if (c == w - 1) push_normal(2 * (su - cur1), 2 * (su - up), c, r, 1'b1);
        end
      end
      older_row[c] = above;
      newer_row[c] = s;
      up_prev      = above;
      cur_prev2    = cur_prev;
      cur_prev     = s;
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= REPORT_CAP) $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task check_normal(normal_t got);
      normal_t want;
      string   diffs;
      normals++;
      if (due.size() == 0) begin
        report($sformatf("normal at column %0d row %0d with none outstanding",
                         got.column, got.row));
        return;
      end
      want  = due.pop_front();
      diffs = "";
      if (got.slope_x !== want.slope_x)
        diffs = {diffs, $sformatf(" slope_x %0d want %0d", got.slope_x, want.slope_x)};
      if (got.slope_y !== want.slope_y)
        diffs = {diffs, $sformatf(" slope_y %0d want %0d", got.slope_y, want.slope_y)};
      if (got.column !== want.column)
        diffs = {diffs, $sformatf(" column %0d want %0d", got.column, want.column)};
      if (got.row !== want.row)
        diffs = {diffs, $sformatf(" row %0d want %0d", got.row, want.row)};
      if (got.frame_end !== want.frame_end)
        diffs = {diffs, $sformatf(" frame_end %0b want %0b", got.frame_end, want.frame_end)};
      if (diffs != "")
        report($sformatf("normal (%0d,%0d):%s", want.column, want.row, diffs));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  bit         quiet = 1'b0;
  int         grids = 0;
  int         idle_cycles = 0;
  normal_t    seen;
  slope_board sb = new();

  hsn_in_if  in_ch ();
  hsn_out_if out_ch ();
  hsn_cfg_if cfg_ch ();

  heightfield_slope_normals_top #(
    .MAX_WIDTH  (GRID_MAX),
    .MAX_HEIGHT (GRID_MAX)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Size words carry random upper bits, which the block must ignore.
  task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input logic [SCALE_W-1:0] sx, input logic [SCALE_W-1:0] sy,
                           input bit set_size);
    logic [CFG_DW-1:0] word;
    if (set_size) begin
      word = CFG_DW'($urandom);
      word[SIZE_W-1:0] = w;
      write_reg(REG_GRID_WIDTH, word);
      word = CFG_DW'($urandom);
      word[SIZE_W-1:0] = h;
      write_reg(REG_GRID_HEIGHT, word);
    end
    write_reg(REG_X_SCALE, sx);
    write_reg(REG_Y_SCALE, sy);
  endtask

  task automatic send_sample(input logic signed [HEIGHT_W-1:0] s);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.height_sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  // Holds the sender back until every outstanding normal has been taken.
  task automatic drain(input int extra);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic logic signed [HEIGHT_W-1:0] next_height(input fill_style_e style,
                                                             input logic signed [HEIGHT_W-1:0] prev);
    int v;
    case (style)
      FILL_GENTLE: v = int'(prev) + int'($urandom_range(0, 64)) - 32;
      FILL_STEEP:  v = int'(prev) + int'($urandom_range(0, 4096)) - 2048;
      FILL_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v[HEIGHT_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(input int unsigned hi);
    case ($urandom_range(0, 9))
      0:       return SIZE_W'($urandom_range(0, 1));
      1:       return SIZE_W'($urandom_range(9, hi));
      default: return SIZE_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return SCALE_RESET;
      3:       return SCALE_W'($urandom_range(1, 64));
      default: return SCALE_W'($urandom);
    endcase
  endfunction

  task automatic run_grid(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                          input logic [SCALE_W-1:0] sx, input logic [SCALE_W-1:0] sy,
                          input bit set_size, input fill_style_e style, input int count,
                          input int pause_at);
    logic signed [HEIGHT_W-1:0] s;
    s     = HEIGHT_W'($urandom);
    quiet = ($urandom_range(0, 3) == 0);
    configure(w, h, sx, sy, set_size);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain(0);
      s = next_height(style, s);
      send_sample(s);
    end
    drain(SETTLE);
    grids++;
  endtask

  task automatic send_pattern(input logic signed [HEIGHT_W-1:0] pat [$]);
    foreach (pat[i]) send_sample(pat[i]);
    drain(SETTLE);
    grids++;
  endtask

  // Result side: a fresh stall before each normal, none while quiet.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.slope_x   = out_ch.slope_x;
      seen.slope_y   = out_ch.slope_y;
      seen.column    = out_ch.column;
      seen.row       = out_ch.row;
      seen.frame_end = out_ch.frame_end;
      sb.check_normal(seen);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: %0d cycles without any transfer, %0d normals outstanding.",
               STALL_LIMIT, sb.due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    int                area;
    int                count;
    int                pause_at;
    int                random_done;
    bit                pressure_owed;
    bit                set_size;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.height_sample = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.addr         = REG_GRID_WIDTH;
    cfg_ch.data         = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme heights on a 3 x 3 grid with unit scale.
    configure(11'd3, 11'd3, SCALE_RESET, SCALE_RESET, 1'b1);
    send_pattern('{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
                   16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA});
    // Sizes below the minimum act as 2; full-scale factors drive saturation.
    configure(11'd0, 11'd1, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pattern('{16'sh0000, 16'sh0001, 16'sh8000, 16'sh7FFF});
    // A grid cut short in its second row, then restarted by a size write.
    configure(11'd3, 11'd2, 16'h0000, 16'h0001, 1'b1);
    send_pattern('{16'sh0100, 16'sh0200, 16'sh0300, 16'sh0400});
    configure(11'd3, 11'd2, 16'h0000, 16'h0001, 1'b1);
    send_pattern('{-16'sd5, 16'sd10, 16'sd20, 16'sh7FFF, -16'sd3, 16'sd0});

    // Random grids, mostly whole ones, some cut short or carried on across a scale change.
    random_done   = 0;
    pressure_owed = 1'b1;
    while (random_done < RANDOM_ITEMS) begin
      set_size = pressure_owed || ($urandom_range(0, 3) != 0);
      if (set_size) begin
        w = pick_size(16);
        h = pick_size(6);
      end else begin
        w = sb.width_reg;
        h = sb.height_reg;
      end
      area  = sb.clamp_size(w) * sb.clamp_size(h);
      count = area * $urandom_range(1, 2);
      if (!pressure_owed && $urandom_range(0, 3) == 0)
        count = $urandom_range(1, area + area / 2);
      if (pressure_owed) begin
        count    = 2 * area;
        pause_at = area;
      end else begin
        pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, count - 1) : -1;
      end
      pressure_owed = 1'b0;
      run_grid(w, h, pick_scale(), pick_scale(), set_size,
               fill_style_e'($urandom_range(0, 3)), count, pause_at);
      random_done += count;
    end

    // Oversized widths and heights clamp to the largest grid; short runs keep the count low.
    run_grid(11'd2047, 11'd2, 16'hFFFF, 16'hFFFF, 1'b1, FILL_GENTLE, 16, -1);
    run_grid(11'd2, 11'd2047, pick_scale(), pick_scale(), 1'b1, FILL_NOISE, 32, -1);

    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d height samples in %0d grid settings, sizes 2 up to %0d per side,",
             sb.samples, grids, GRID_MAX);
    $display("with scales from 0 to full range; %0d normals compared, %0d mismatches.",
             sb.normals, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
